>>> hdl/spfa_pkg.sv
// Package for the sprite pixel fetch address block.
// Holds the payload structs, shape codes, size tables and default parameters.
// No dependencies.
package spfa_pkg;

  localparam int DEF_SCREEN_WIDTH  = 240;
  localparam int DEF_SCREEN_HEIGHT = 160;
  localparam int DEF_QUEUE_DEPTH   = 2;

  localparam logic [1:0] SHAPE_WIDE = 2'd1;
  localparam logic [1:0] SHAPE_TALL = 2'd2;

  localparam logic [3:0] LONG_SIDE  [4] = '{4'd2, 4'd4, 4'd4, 4'd8};
  localparam logic [3:0] SHORT_SIDE [4] = '{4'd1, 4'd1, 4'd2, 4'd4};

  typedef struct packed {
    logic [15:0] attr_word0;
    logic [15:0] attr_word1;
    logic [15:0] attr_word2;
    logic [5:0]  pixel_col;
    logic [5:0]  pixel_row;
  } spfa_in_t;

  typedef struct packed {
    logic        visible;
    logic        on_screen;
    logic [9:0]  screen_x;
    logic [8:0]  screen_y;
    logic [15:0] tile_byte_offset;
    logic        high_nibble;
    logic        eight_bit_depth;
    logic [7:0]  palette_base;
    logic [3:0]  width_tiles;
    logic [3:0]  height_tiles;
  } spfa_out_t;

  // Decoded item passed from the front part to the back part.
  typedef struct packed {
    logic        visible;
    logic        on_screen;
    logic [9:0]  screen_x;
    logic [8:0]  screen_y;
    logic        in_sprite;
    logic        deep;
    logic [7:0]  palette_base;
    logic [3:0]  width_tiles;
    logic [3:0]  height_tiles;
    logic [9:0]  base_tile;
    logic [2:0]  tile_x;
    logic [2:0]  tile_y;
    logic [2:0]  pix_x;
    logic [2:0]  pix_y;
  } spfa_work_t;

endpackage

>>> hdl/spfa_fifo.sv
// Small register-based queue with show-ahead head.
// Generic width and depth; no package dependencies.
module spfa_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

>>> hdl/spfa_front.sv
// Front part: classifies one sprite pixel request into a decoded work item.
// Depends on spfa_pkg.
module spfa_front #(
  parameter int SCREEN_WIDTH  = spfa_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = spfa_pkg::DEF_SCREEN_HEIGHT
) (
  input  spfa_pkg::spfa_in_t   req,
  output spfa_pkg::spfa_work_t work
);
  import spfa_pkg::*;

  logic [1:0] shape;
  logic [1:0] size;
  logic [3:0] w;
  logic [3:0] h;
  logic [6:0] w_pix;
  logic [6:0] h_pix;
  logic       in_sprite;
  logic       enabled;
  logic [9:0] sx;
  logic [8:0] sy;
  logic       on_scr;
  logic [6:0] col_flip;
  logic [6:0] row_flip;
  logic [5:0] c;
  logic [5:0] r;
  logic       deep;

  assign shape = req.attr_word0[15:14];
  assign size  = req.attr_word1[15:14];
  assign deep  = req.attr_word0[13];

  always_comb begin
    unique case (shape)
      SHAPE_WIDE: begin
        w = LONG_SIDE[size];
        h = SHORT_SIDE[size];
      end
      SHAPE_TALL: begin
        w = SHORT_SIDE[size];
        h = LONG_SIDE[size];
      end
      default: begin
        // square, and the prohibited shape treated as square
        w = 4'(4'd1 << size);
        h = 4'(4'd1 << size);
      end
    endcase
  end

  assign w_pix     = {w, 3'b000};
  assign h_pix     = {h, 3'b000};
  assign in_sprite = ({1'b0, req.pixel_col} < w_pix) && ({1'b0, req.pixel_row} < h_pix);
  assign enabled   = req.attr_word0[8] || !req.attr_word0[9];

  assign sx     = {1'b0, req.attr_word1[8:0]} + {4'd0, req.pixel_col};
  assign sy     = {1'b0, req.attr_word0[7:0]} + {3'd0, req.pixel_row};
  assign on_scr = ({1'b0, sx} < 11'(SCREEN_WIDTH)) && ({1'b0, sy} < 10'(SCREEN_HEIGHT));

  // Mirror across the whole sprite; only meaningful when inside.
  assign col_flip = w_pix - 7'd1 - {1'b0, req.pixel_col};
  assign row_flip = h_pix - 7'd1 - {1'b0, req.pixel_row};
  assign c = req.attr_word1[12] ? col_flip[5:0] : req.pixel_col;
  assign r = req.attr_word1[13] ? row_flip[5:0] : req.pixel_row;

  always_comb begin
    work.visible      = enabled && in_sprite && on_scr;
    work.on_screen    = on_scr;
    work.screen_x     = sx;
    work.screen_y     = sy;
    work.in_sprite    = in_sprite;
    work.deep         = deep;
    work.palette_base = deep ? 8'd0 : {req.attr_word2[15:12], 4'd0};
    work.width_tiles  = w;
    work.height_tiles = h;
    work.base_tile    = req.attr_word2[9:0];
    work.tile_x       = c[5:3];
    work.tile_y       = r[5:3];
    work.pix_x        = c[2:0];
    work.pix_y        = r[2:0];
  end

endmodule

>>> hdl/spfa_back.sv
// Back part: turns a decoded work item into the tile byte offset and result.
// Depends on spfa_pkg.
module spfa_back (
  input  logic                 one_dim_mapping,
  input  spfa_pkg::spfa_work_t work,
  input  logic                 work_empty,
  output logic                 work_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output spfa_pkg::spfa_out_t  res
);
  import spfa_pkg::*;

  logic [6:0]  lin_tile;
  logic [15:0] tile_off;
  logic [5:0]  pix_off;
  logic [15:0] offset;

  // Advance whenever a work item waits and the result queue has room.
  assign work_pop = !work_empty && !res_full;
  assign res_push = work_pop;

  assign lin_tile = 7'(work.tile_y * work.width_tiles) + {4'd0, work.tile_x};

  always_comb begin
    if (one_dim_mapping) begin
      tile_off = work.deep ? {3'd0, lin_tile, 6'd0} : {4'd0, lin_tile, 5'd0};
    end else begin
      tile_off = {3'd0, work.tile_y, 10'd0}
               + (work.deep ? {7'd0, work.tile_x, 6'd0} : {8'd0, work.tile_x, 5'd0});
    end
    pix_off = work.deep ? {work.pix_y, work.pix_x}
                        : {1'b0, work.pix_y, work.pix_x[2:1]};
    offset  = {1'b0, work.base_tile, 5'd0} + tile_off + {10'd0, pix_off};
  end

  always_comb begin
    res.visible          = work.visible;
    res.on_screen        = work.on_screen;
    res.screen_x         = work.screen_x;
    res.screen_y         = work.screen_y;
    res.tile_byte_offset = work.in_sprite ? offset : 16'd0;
    res.high_nibble      = work.in_sprite && !work.deep && work.pix_x[0];
    res.eight_bit_depth  = work.deep;
    res.palette_base     = work.palette_base;
    res.width_tiles      = work.width_tiles;
    res.height_tiles     = work.height_tiles;
  end

endmodule

>>> hdl/sprite_pixel_fetch_address.sv
// Sprite pixel fetch address: top level.
// Items pass from the input port through the front, the work queue, the back
// stage and the result queue. Throughput: one item per cycle while neither
// QUEUE_DEPTH-entry queue is full; the back stage is combinational.
// Reset (rst, synchronous): empties both queues and clears one_dim_mapping.
module sprite_pixel_fetch_address #(
  parameter int SCREEN_WIDTH  = spfa_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = spfa_pkg::DEF_SCREEN_HEIGHT,
  parameter int QUEUE_DEPTH   = spfa_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  // input item queue side
  input  logic                push,
  output logic                full,
  input  spfa_pkg::spfa_in_t  req,
  // result queue side
  output logic                empty,
  input  logic                pop,
  output spfa_pkg::spfa_out_t result,
  // configuration
  input  logic                cfg_write,
  input  logic                cfg_data
);
  import spfa_pkg::*;

  localparam int WORK_W = $bits(spfa_work_t);
  localparam int RES_W  = $bits(spfa_out_t);

  logic       one_dim_mapping;
  spfa_work_t front_work;
  spfa_work_t work_head;
  logic       work_empty;
  logic       work_pop;
  logic       res_full;
  logic       res_push;
  spfa_out_t  back_res;

  // Mapping mode register; the user must write it only while the block is idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      one_dim_mapping <= 1'b0;
    end else if (cfg_write) begin
      one_dim_mapping <= cfg_data;
    end
  end

  // Front: decode the attribute words and pixel position.
  spfa_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .req  (req),
    .work (front_work)
  );

  // Queue between front and back; its full flag is the block's full.
  spfa_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (front_work),
    .full  (full),
    .pop   (work_pop),
    .rdata (work_head),
    .empty (work_empty)
  );

  // Back: compute tile byte offset, nibble select and build the result item.
  spfa_back u_back (
    .one_dim_mapping (one_dim_mapping),
    .work            (work_head),
    .work_empty      (work_empty),
    .work_pop        (work_pop),
    .res_full        (res_full),
    .res_push        (res_push),
    .res             (back_res)
  );

  // Result queue: holds finished items until the consumer pops them.
  spfa_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

>>> test/spfa_checker.sv
// Checker for sprite_pixel_fetch_address: watches the item, result and mapping ports.
// Predicts every result from the accepted item and compares it field by field.
// Depends on spfa_pkg.
`timescale 1ns / 1ps
module spfa_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  spfa_pkg::spfa_in_t  req,
  input  logic                empty,
  input  logic                pop,
  input  spfa_pkg::spfa_out_t result,
  input  logic                cfg_write,
  input  logic                cfg_data,
  output int                  mismatches,
  output int                  outstanding
);
  import spfa_pkg::*;

  localparam int          SCREEN_W     = DEF_SCREEN_WIDTH;
  localparam int          SCREEN_H     = DEF_SCREEN_HEIGHT;
  localparam int          PRINT_LIMIT  = 40;
  // Tiles along the long and short side, one nibble per size code.
  localparam logic [15:0] LONG_TILES   = {4'd8, 4'd4, 4'd4, 4'd2};
  localparam logic [15:0] SHORT_TILES  = {4'd4, 4'd2, 4'd1, 4'd1};

  logic      linear_map;
  spfa_out_t pending_pixels[$];
  int        fail_count = 0;
  int        queued = 0;
  int        results_seen = 0;

  assign mismatches  = fail_count;
  assign outstanding = queued;

  function automatic spfa_out_t predict_pixel(spfa_in_t it, logic linear);
    spfa_out_t   o;
    logic [1:0]  shape;
    logic [1:0]  size;
    logic        deep;
    logic        enabled;
    logic        in_sprite;
    int unsigned w, h, c, r, sx, sy, bytes_per_tile, tile_off, pix_off, offset;
    shape   = it.attr_word0[15:14];
    size    = it.attr_word1[15:14];
    deep    = it.attr_word0[13];
    enabled = it.attr_word0[8] | ~it.attr_word0[9];
    case (shape)
      SHAPE_WIDE: begin
        w = 32'(LONG_TILES[size*4 +: 4]);
        h = 32'(SHORT_TILES[size*4 +: 4]);
      end
      SHAPE_TALL: begin
        w = 32'(SHORT_TILES[size*4 +: 4]);
        h = 32'(LONG_TILES[size*4 +: 4]);
      end
      default: begin
        w = 1 << size;
        h = w;
      end
    endcase
    in_sprite = (32'(it.pixel_col) < w * 8) && (32'(it.pixel_row) < h * 8);
    sx = 32'(it.attr_word1[8:0]) + 32'(it.pixel_col);
    sy = 32'(it.attr_word0[7:0]) + 32'(it.pixel_row);
    o = '0;
    o.on_screen = (sx < SCREEN_W) && (sy < SCREEN_H);
    o.visible   = enabled && in_sprite && o.on_screen;
    o.screen_x  = sx[9:0];
    o.screen_y  = sy[8:0];
    if (in_sprite) begin
      // Flips mirror across the whole sprite, not within each tile.
      c = it.attr_word1[12] ? (w * 8 - 1 - 32'(it.pixel_col)) : 32'(it.pixel_col);
      r = it.attr_word1[13] ? (h * 8 - 1 - 32'(it.pixel_row)) : 32'(it.pixel_row);
      bytes_per_tile = deep ? 64 : 32;
      if (linear)
        tile_off = ((r >> 3) * w + (c >> 3)) * bytes_per_tile;
      else
        tile_off = (r >> 3) * 1024 + (c >> 3) * bytes_per_tile;
      if (deep) begin
        pix_off = (c & 7) + ((r & 7) << 3);
      end else begin
        pix_off = ((c & 7) >> 1) + ((r & 7) << 2);
        o.high_nibble = c[0];
      end
      offset = 32'(it.attr_word2[9:0]) * 32 + tile_off + pix_off;
      o.tile_byte_offset = offset[15:0];
    end
    o.eight_bit_depth = deep;
    o.palette_base    = deep ? 8'h00 : {it.attr_word2[15:12], 4'h0};
    o.width_tiles     = w[3:0];
    o.height_tiles    = h[3:0];
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    fail_count++;
    if (fail_count <= PRINT_LIMIT) $display("checker: %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h",
                                results_seen, name, got, want));
  endtask

  always @(posedge clk) begin
    spfa_out_t want;
    if (rst) begin
      linear_map <= 1'b0;
      pending_pixels.delete();
      queued <= 0;
    end else begin
      if (cfg_write) linear_map <= cfg_data;
      // Check the popped result before recording a newly accepted item, so an unregistered pass-through cannot hide.
      if (pop && !empty) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing pending", results_seen));
        end else begin
          want = pending_pixels.pop_front();
          check_field("visible", 16'(result.visible), 16'(want.visible));
          check_field("on_screen", 16'(result.on_screen), 16'(want.on_screen));
          check_field("screen_x", 16'(result.screen_x), 16'(want.screen_x));
          check_field("screen_y", 16'(result.screen_y), 16'(want.screen_y));
          check_field("tile_byte_offset", result.tile_byte_offset,
                      want.tile_byte_offset);
          check_field("high_nibble", 16'(result.high_nibble), 16'(want.high_nibble));
          check_field("eight_bit_depth", 16'(result.eight_bit_depth),
                      16'(want.eight_bit_depth));
          check_field("palette_base", 16'(result.palette_base), 16'(want.palette_base));
          check_field("width_tiles", 16'(result.width_tiles), 16'(want.width_tiles));
          check_field("height_tiles", 16'(result.height_tiles), 16'(want.height_tiles));
        end
        results_seen++;
      end
      if (push && !full) pending_pixels.push_back(predict_pixel(req, linear_map));
      queued <= pending_pixels.size();
    end
  end

endmodule

>>> test/tb.sv
// Top-level testbench for sprite_pixel_fetch_address: clock, reset, item and
// result traffic, mapping writes, watchdog and verdict. Depends on spfa_pkg,
// spfa_checker and the block itself.
`timescale 1ns / 1ps
module tb;
  import spfa_pkg::*;

  localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int HOLD_ITEMS     = 30;    // items offered back to back during it
  localparam int PHASE_ITEMS    = 250;   // random items per mapping setting
  localparam int SETTLE_CYCLES  = 4;     // extra wait after the last result is popped
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      cfg_write = 1'b0;
  logic      cfg_data = 1'b0;
  spfa_in_t  req = '0;
  logic      full;
  logic      empty;
  spfa_out_t result;
  int        mismatches;
  int        outstanding;
  int        idle_cycles = 0;
  bit        hold_request = 1'b0;
  bit        holding = 1'b0;
  bit        send_steady = 1'b0;

  always #1 clk = ~clk;

  sprite_pixel_fetch_address dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .empty     (empty),
    .pop       (pop),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  spfa_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .req         (req),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Mostly short gaps, now and then a long one; zero while in a steady stretch.
  function automatic int pick_gap(bit steady);
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic spfa_in_t pixel_req(logic [15:0] a0, logic [15:0] a1, logic [15:0] a2,
                                         logic [5:0] col, logic [5:0] row);
    spfa_in_t it;
    it.attr_word0 = a0;
    it.attr_word1 = a1;
    it.attr_word2 = a2;
    it.pixel_col  = col;
    it.pixel_row  = row;
    return it;
  endfunction

  // Most items are enabled sprites with the pixel near or inside the box and
  // often on screen; the rest are raw random words for full bit coverage.
  function automatic spfa_in_t random_pixel();
    spfa_in_t it;
    it = pixel_req(16'($urandom), 16'($urandom), 16'($urandom),
                   6'($urandom), 6'($urandom));
    if ($urandom_range(0, 3) != 0) begin
      it.attr_word0[9] = 1'b0;
      it.pixel_col = 6'($urandom_range(0, (8 << $urandom_range(0, 3)) - 1));
      it.pixel_row = 6'($urandom_range(0, (8 << $urandom_range(0, 3)) - 1));
      if ($urandom_range(0, 1)) begin
        it.attr_word1[8:0] = 9'($urandom_range(0, 239));
        it.attr_word0[7:0] = 8'($urandom_range(0, 159));
      end
    end
    return it;
  endfunction

  // Offer one item after an optional gap and hold it until accepted. Leave
  // push high afterwards so back-to-back items need no second assignment.
  task automatic offer_item(spfa_in_t it, int gap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    req  <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Stop offering and wait until every pending result has been popped.
  task automatic drain_results();
    push <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the mapping register while the block is idle.
  task automatic write_mapping(logic linear);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data  <= linear;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
      offer_item(random_pixel(), pick_gap(send_steady));
      if (with_hold && i == count / 2) begin
        // Ask the receiver for a long hold-off, then keep pushing so the
        // queues fill up and full stalls the input side.
        push <= 1'b0;
        hold_request = 1'b1;
        wait (holding);
        for (int j = 0; j < HOLD_ITEMS; j++) offer_item(random_pixel(), 0);
      end
    end
  endtask

  // Receiver: pop in random bursts separated by random gaps. A hold request
  // from the stimulus turns one gap into a long stretch counted here.
  initial begin : result_drain
    int  gap;
    bit  steady;
    steady = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 63) == 0) steady = !steady;
      gap = pick_gap(steady);
      if (hold_request) begin
        gap = HOLD_CYCLES;
        hold_request = 1'b0;
        holding = 1'b1;
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      holding = 1'b0;
      pop <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Watchdog: count cycles in which neither side moves an item.
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed items in two-dimensional mapping.
    write_mapping(1'b0);
    offer_item(pixel_req(16'h0000, 16'h0000, 16'h0000, 6'd0, 6'd0), 0);
    offer_item(pixel_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 6'd63, 6'd63), 0);
    // square 64x64 at 8-bit depth, far corner
    offer_item(pixel_req(16'h2000, 16'hC000, 16'h0005, 6'd63, 6'd63), 0);
    // wide and tall shapes at their largest inside pixel
    offer_item(pixel_req(16'h4000, 16'hC000, 16'h0010, 6'd63, 6'd31), 0);
    offer_item(pixel_req(16'h8000, 16'h8000, 16'h0020, 6'd15, 6'd31), 1);
    // prohibited shape behaves as square: last inside column, then one past it
    offer_item(pixel_req(16'hC000, 16'h4000, 16'h0001, 6'd15, 6'd15), 0);
    offer_item(pixel_req(16'hC000, 16'h4000, 16'h0001, 6'd16, 6'd15), 0);
    // pixel outside an 8x8 sprite: offset and nibble drop to zero
    offer_item(pixel_req(16'h0000, 16'h0000, 16'h0100, 6'd8, 6'd0), 2);
    // horizontal, vertical and both flips
    offer_item(pixel_req(16'h0000, 16'h5000, 16'h0040, 6'd3, 6'd5), 0);
    offer_item(pixel_req(16'h0000, 16'h6000, 16'h0040, 6'd3, 6'd5), 0);
    offer_item(pixel_req(16'h2000, 16'h7000, 16'h0040, 6'd3, 6'd5), 0);
    // affine bit keeps the sprite enabled and still takes the flips
    offer_item(pixel_req(16'h0100, 16'h3000, 16'h0002, 6'd1, 6'd2), 0);
    offer_item(pixel_req(16'h0300, 16'h0000, 16'h0002, 6'd1, 6'd2), 0);
    // disabled sprite
    offer_item(pixel_req(16'h0200, 16'h0000, 16'h0002, 6'd1, 6'd2), 3);
    // right and bottom screen borders, and the largest screen position
    offer_item(pixel_req(16'h4000, 16'h80EF, 16'h0000, 6'd0, 6'd0), 0);
    offer_item(pixel_req(16'h4000, 16'h80EF, 16'h0000, 6'd1, 6'd0), 0);
    offer_item(pixel_req(16'h809F, 16'h8000, 16'h0000, 6'd0, 6'd0), 0);
    offer_item(pixel_req(16'h809F, 16'h8000, 16'h0000, 6'd0, 6'd1), 0);
    offer_item(pixel_req(16'h00FF, 16'hC1FF, 16'h0000, 6'd63, 6'd63), 0);
    // largest base tile at the largest offset
    offer_item(pixel_req(16'h6000, 16'hC000, 16'h03FF, 6'd63, 6'd31), 0);
    // top palette bank at 4-bit depth, odd column takes the upper nibble
    offer_item(pixel_req(16'h0000, 16'h4000, 16'hF000, 6'd1, 6'd0), 0);
    offer_item(pixel_req(16'h0000, 16'h4000, 16'hF000, 6'd2, 6'd9), 0);

    // Random items, alternating the mapping; the first phase also fills the
    // block under a long receiver hold-off.
    write_mapping(1'b1);
    random_phase(PHASE_ITEMS, 1'b1);
    write_mapping(1'b0);
    random_phase(PHASE_ITEMS, 1'b0);
    write_mapping(1'b1);
    random_phase(PHASE_ITEMS, 1'b0);
    write_mapping(1'b0);
    random_phase(PHASE_ITEMS, 1'b0);

    drain_results();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/spfa_pkg.sv
hdl/spfa_fifo.sv
hdl/spfa_front.sv
hdl/spfa_back.sv
hdl/sprite_pixel_fetch_address.sv
test/spfa_checker.sv
test/tb.sv
